// ===== design/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal unit
// Widths of the vertex store, the item fields and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package tfn_pkg;
    localparam int MaxVertices = 1024;
    localparam int CoordBits   = 24;
    localparam int SlotBits    = $clog2(MaxVertices);
    localparam int EdgeBits    = CoordBits + 1;
    localparam int CrossBits   = 2 * EdgeBits + 1;
    localparam int MagBits     = 30;
    localparam int SumBits     = 2 * MagBits + 2;
    localparam int RootBits    = SumBits / 2;
    localparam int QuotBits    = 15;
    localparam int OutBits     = 16;
    // Dividend is a magnitude scaled by 2^14: one step per dividend bit
    localparam int DivSteps    = MagBits + 14;
    localparam logic [QuotBits-1:0] OneQ14 = 15'd16384;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_EDGE, ST_MUL, ST_NORM,
        ST_SQR, ST_ROOT, ST_DIV, ST_OUT
    } t_state;

    // Request to the shared divide/root unit.
    typedef struct packed {
        logic                 start;
        logic                 root;
        logic [SumBits-1:0]   num;
        logic [RootBits-1:0]  den;
    } t_alu_req;

    typedef struct packed {
        logic                 done;
        logic [RootBits-1:0]  res;
    } t_alu_rsp;
endpackage
`default_nettype wire

// ===== design/triangle_face_normal_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_unit: flat shading face normal from a vertex store
// Stores Q12.12 vertices and turns triangle items into Q1.14 unit normals.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items. tuser = op (0 vertex write, 1 triangle request),
//   tlast = final_item. tdata fields from bit 0: vertex_slot[9:0],
//   pos_x[33:10], pos_y[57:34], pos_z[81:58], corner_a[91:82],
//   corner_b[101:92], corner_c[111:102].
//   m_axis carries one result per triangle: tlast = mesh_done, tuser =
//   degenerate, tdata from bit 0: normal_x, normal_y, normal_z (16 each),
//   out_corner_a/b/c (10 each), two zero pad bits.
//   A vertex write is taken while idle; writes can follow back to back. A
//   triangle runs through store reads and edges, six products on the shared
//   multiplier, a range check that shifts the cross product down a bit per
//   pass (up to 19 bits), squares, a 31-step square root and three 44-step
//   divisions on the one serial divide/root unit, and the output load. A
//   degenerate triangle goes from the range check straight to the output load.
//   The result sits in an output register, so items are taken while it waits;
//   a finished triangle holds in its last state until the receiver takes the
//   previous result. Reset clears the sequencer and the output valid; the
//   vertex store is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_face_normal_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  wire logic [111:0] s_axis_tdata,
    // op
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // normal_x, normal_y, normal_z, out_corner_a, out_corner_b, out_corner_c
    output logic [79:0]       m_axis_tdata,
    // degenerate
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    localparam int CB = tfn_pkg::CoordBits;
    localparam int SL = tfn_pkg::SlotBits;
    localparam int EB = tfn_pkg::EdgeBits;
    localparam int XB = tfn_pkg::CrossBits;
    localparam int MB = tfn_pkg::MagBits;
    localparam int SB = tfn_pkg::SumBits;
    localparam int RB = tfn_pkg::RootBits;
    localparam int QB = tfn_pkg::QuotBits;
    localparam int OB = tfn_pkg::OutBits;

    tfn_pkg::t_state r_state, n_state;
    logic [3*CB-1:0] r_mem [tfn_pkg::MaxVertices];
    logic [3*CB-1:0] r_rd;
    logic [SL-1:0]   r_ca, r_cb, r_cc, w_rd_addr;
    logic            r_last;
    logic [3*CB-1:0] r_pa, r_pb;
    logic signed [EB-1:0] r_e1 [3];
    logic signed [EB-1:0] r_e2 [3];
    logic signed [XB-1:0] r_cr [3];
    logic [XB-1:0]   r_m [3];
    logic [1:0]      r_idx;
    logic signed [2*EB-1:0] r_p0;
    logic [SB-1:0]   r_sum;
    logic [RB-1:0]   r_r;
    logic [OB-1:0]   r_nrm [3];
    logic            r_deg;
    logic            r_req_sent;
    logic            r_ovalid;
    logic [79:0]     r_odata;
    logic            r_odeg;
    logic            r_olast;

    tfn_pkg::t_alu_req w_req;
    tfn_pkg::t_alu_rsp w_rsp;

    logic w_in_acc;
    logic w_out_load;
    logic [1:0] w_i1, w_i2;
    logic signed [EB-1:0] w_ma, w_mb;
    logic signed [2*EB-1:0] w_prod;
    logic [2*MB-1:0] w_msq;
    logic [XB-1:0] w_top;
    logic [MB-1:0] w_m;
    logic [QB-1:0] w_q;

    assign s_axis_tready = (r_state == tfn_pkg::ST_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == tfn_pkg::ST_OUT) && (!r_ovalid || m_axis_tready);

    // Store vertex writes; read one corner a cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !s_axis_tuser)
            r_mem[s_axis_tdata[SL-1:0]] <= s_axis_tdata[SL +: 3*CB];
        r_rd <= r_mem[w_rd_addr];
    end

    always_comb begin
        w_rd_addr = r_ca;
        if (r_state == tfn_pkg::ST_RD_B) w_rd_addr = r_cb;
        if (r_state == tfn_pkg::ST_RD_C) w_rd_addr = r_cc;
    end

    // Cross product operand select: two products per component
    always_comb begin
        case (r_idx)
            2'd0:    begin w_i1 = 2'd1; w_i2 = 2'd2; end
            2'd1:    begin w_i1 = 2'd2; w_i2 = 2'd0; end
            default: begin w_i1 = 2'd0; w_i2 = 2'd1; end
        endcase
    end

    always_comb begin
        w_ma = r_req_sent ? r_e1[w_i2] : r_e1[w_i1];
        w_mb = r_req_sent ? r_e2[w_i1] : r_e2[w_i2];
        w_prod = w_ma * w_mb;
        w_top = r_m[0];
        if (r_m[1] > w_top) w_top = r_m[1];
        if (r_m[2] > w_top) w_top = r_m[2];
        w_m = r_m[r_idx][MB-1:0];
        w_msq = w_m * w_m;
        w_q = (w_rsp.res[QB-1:0] > tfn_pkg::OneQ14 || w_rsp.res[RB-1:QB] != '0)
              ? tfn_pkg::OneQ14 : w_rsp.res[QB-1:0];
    end

    // Shared unit requests
    always_comb begin
        w_req = '0;
        if (r_state == tfn_pkg::ST_ROOT && !r_req_sent) begin
            w_req.start = 1'b1; w_req.root = 1'b1; w_req.num = r_sum;
        end else if (r_state == tfn_pkg::ST_DIV && !r_req_sent) begin
            w_req.start = 1'b1;
            w_req.num = SB'({w_m, 14'd0}) << (SB - tfn_pkg::DivSteps);
            w_req.den = (r_r == '0) ? RB'(1) : r_r;
        end
    end

    tfn_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfn_pkg::ST_IDLE: if (w_in_acc && s_axis_tuser) n_state = tfn_pkg::ST_RD_A;
            tfn_pkg::ST_RD_A: n_state = tfn_pkg::ST_RD_B;
            tfn_pkg::ST_RD_B: n_state = tfn_pkg::ST_RD_C;
            tfn_pkg::ST_RD_C: n_state = tfn_pkg::ST_EDGE;
            tfn_pkg::ST_EDGE: n_state = tfn_pkg::ST_MUL;
            tfn_pkg::ST_MUL:  if (r_req_sent && r_idx == 2'd2) n_state = tfn_pkg::ST_NORM;
            tfn_pkg::ST_NORM: begin
                if (r_cr[0] == '0 && r_cr[1] == '0 && r_cr[2] == '0)
                    n_state = tfn_pkg::ST_OUT;
                else if (w_top < (XB'(1) << MB))
                    n_state = tfn_pkg::ST_SQR;
            end
            tfn_pkg::ST_SQR:  if (r_idx == 2'd2) n_state = tfn_pkg::ST_ROOT;
            tfn_pkg::ST_ROOT: if (w_rsp.done) n_state = tfn_pkg::ST_DIV;
            tfn_pkg::ST_DIV:  if (w_rsp.done && r_idx == 2'd2) n_state = tfn_pkg::ST_OUT;
            tfn_pkg::ST_OUT:  if (w_out_load) n_state = tfn_pkg::ST_IDLE;
            default:          n_state = tfn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfn_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_req_sent <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                tfn_pkg::ST_MUL: begin
                    r_req_sent <= !r_req_sent;
                    if (r_req_sent) r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                tfn_pkg::ST_SQR: r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                tfn_pkg::ST_ROOT: begin
                    r_req_sent <= w_rsp.done ? 1'b0 : 1'b1;
                end
                tfn_pkg::ST_DIV: begin
                    if (w_rsp.done) begin
                        r_req_sent <= 1'b0;
                        r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                    end else begin
                        r_req_sent <= 1'b1;
                    end
                end
                default: begin
                    r_req_sent <= 1'b0;
                    r_idx <= '0;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser) begin
            r_ca <= s_axis_tdata[SL+3*CB +: SL];
            r_cb <= s_axis_tdata[2*SL+3*CB +: SL];
            r_cc <= s_axis_tdata[3*SL+3*CB +: SL];
            r_last <= s_axis_tlast;
        end
        case (r_state)
            tfn_pkg::ST_RD_B: r_pa <= r_rd;
            tfn_pkg::ST_RD_C: r_pb <= r_rd;
            tfn_pkg::ST_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= EB'($signed(r_pb[k*CB +: CB])) - EB'($signed(r_pa[k*CB +: CB]));
                    r_e2[k] <= EB'($signed(r_rd[k*CB +: CB])) - EB'($signed(r_pa[k*CB +: CB]));
                end
                r_deg <= 1'b0;
            end
            tfn_pkg::ST_MUL: begin
                if (!r_req_sent) begin
                    r_p0 <= w_prod;
                end else begin
                    r_cr[r_idx] <= XB'(r_p0) - XB'(w_prod);
                    r_m[r_idx]  <= (r_p0 < w_prod) ? XB'(w_prod) - XB'(r_p0)
                                                   : XB'(r_p0) - XB'(w_prod);
                end
            end
            tfn_pkg::ST_NORM: begin
                r_sum <= '0;
                if (r_cr[0] == '0 && r_cr[1] == '0 && r_cr[2] == '0) begin
                    r_deg <= 1'b1;
                    for (int k = 0; k < 3; k++) r_nrm[k] <= '0;
                end else if (w_top >= (XB'(1) << MB)) begin
                    for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
                end
            end
            tfn_pkg::ST_SQR: r_sum <= r_sum + SB'(w_msq);
            tfn_pkg::ST_ROOT: if (w_rsp.done) r_r <= w_rsp.res;
            tfn_pkg::ST_DIV: begin
                if (w_rsp.done)
                    r_nrm[r_idx] <= r_cr[r_idx][XB-1] ? OB'(0) - OB'(w_q) : OB'(w_q);
            end
            // Load the result once the output register is free
            tfn_pkg::ST_OUT: begin
                if (w_out_load) begin
                    r_odata <= {2'b00, r_cc, r_cb, r_ca, r_nrm[2], r_nrm[1], r_nrm[0]};
                    r_odeg  <= r_deg;
                    r_olast <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_odeg;
    assign m_axis_tlast  = r_olast;
endmodule
`default_nettype wire

// ===== design/tfn_alu.sv =====
// ----------------------------------------------------------------------------
// tfn_alu: shared serial unit for integer square root and division
// Produces one result bit per cycle; division leaves a 31-bit quotient in the result.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tfn_pkg::t_alu_req i_req,
    output tfn_pkg::t_alu_rsp      o_rsp
);
    localparam int SB = tfn_pkg::SumBits;
    localparam int RB = tfn_pkg::RootBits;
    localparam int DS = tfn_pkg::DivSteps;

    logic          r_busy, n_busy;
    logic          r_root, n_root;
    logic [5:0]    r_cnt, n_cnt;
    logic [SB-1:0] r_num, n_num;
    logic [SB+1:0] r_rem, n_rem;
    logic [RB-1:0] r_res, n_res;
    logic [RB-1:0] r_den, n_den;
    logic          r_done, n_done;
    logic [SB+1:0] w_trial;

    always_comb begin
        n_busy = r_busy; n_root = r_root; n_cnt = r_cnt; n_num = r_num;
        n_rem = r_rem; n_res = r_res; n_den = r_den; n_done = 1'b0;
        w_trial = '0;
        if (i_req.start) begin
            n_busy = 1'b1; n_root = i_req.root; n_num = i_req.num; n_den = i_req.den;
            n_rem = '0; n_res = '0;
            n_cnt = i_req.root ? 6'(RB) : 6'(DS);
        end else if (r_busy) begin
            // Take two bits (root) or one bit (divide) per step
            if (r_root) begin
                n_rem   = {r_rem[SB-1:0], r_num[SB-1 -: 2]};
                n_num   = {r_num[SB-3:0], 2'b00};
                w_trial = {(SB+2-RB-2)'(0), r_res, 2'b01};
                if (n_rem >= w_trial) begin
                    n_rem = n_rem - w_trial;
                    n_res = {r_res[RB-2:0], 1'b1};
                end else begin
                    n_res = {r_res[RB-2:0], 1'b0};
                end
            end else begin
                n_rem   = {r_rem[SB:0], r_num[SB-1]};
                n_num   = {r_num[SB-2:0], 1'b0};
                w_trial = {(SB+2-RB)'(0), r_den};
                if (n_rem >= w_trial) begin
                    n_rem = n_rem - w_trial;
                    n_res = {r_res[RB-2:0], 1'b1};
                end else begin
                    n_res = {r_res[RB-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_root <= n_root; r_num <= n_num; r_rem <= n_rem;
        r_res <= n_res; r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule
`default_nettype wire

// ===== design/tfn_checker.sv =====
// ----------------------------------------------------------------------------
// tfn_checker: port-level checks of the triangle face normal unit
// Watches the stream handshakes and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [79:0]  m_axis_tdata,
    input wire logic         m_axis_tuser
);
    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A degenerate result carries a zero normal
    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == 48'd0)
        else $error("degenerate result with nonzero normal");

    // A vertex write leaves the block ready for the next item
    a_vtx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
        else $error("not ready after vertex item");

    // A triangle item makes the block busy next cycle
    a_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("ready right after triangle item");
endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

// ===== bench/triangle_face_normal_unit_test.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_unit_test: bench for the triangle face normal unit
// Writes vertices, sends triangle items and checks each unit normal against
// a behavioral model of the vertex store, cross product and normalization.
// Both sides idle at random; one phase holds off the receiver for a long
// stretch so the block stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_face_normal_unit_test;
    localparam logic OP_VERTEX   = 1'b0;
    localparam logic OP_TRIANGLE = 1'b1;
    localparam int   CycleLimit  = 1000000;
    localparam int   DrainCycles = 400;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [9:0]         ca;
        logic [9:0]         cb;
        logic [9:0]         cc;
        logic               degen;
        logic               done;
    } t_face;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    // Model state: stored positions and which slots hold one
    longint vtx_x [tfn_pkg::MaxVertices];
    longint vtx_y [tfn_pkg::MaxVertices];
    longint vtx_z [tfn_pkg::MaxVertices];
    int     filled_slots[$];
    bit     slot_filled [tfn_pkg::MaxVertices];

    t_face  pending_faces[$];
    int     errors;
    int     faces_seen;
    int     cycles;
    bit     hold_off;
    bit     no_idle;

    triangle_face_normal_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("triangle_face_normal_unit: mismatch");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Cross product of the edges from corner a to corners b and c, scaled to Q1.14
    function automatic t_face face_normal(input int a, input int b, input int c,
                                          input logic last);
        t_face           f;
        longint          e1 [3];
        longint          e2 [3];
        longint          cr [3];
        longint unsigned m  [3];
        longint unsigned top;
        longint unsigned r;
        longint unsigned k;
        e1[0] = vtx_x[b] - vtx_x[a];
        e1[1] = vtx_y[b] - vtx_y[a];
        e1[2] = vtx_z[b] - vtx_z[a];
        e2[0] = vtx_x[c] - vtx_x[a];
        e2[1] = vtx_y[c] - vtx_y[a];
        e2[2] = vtx_z[c] - vtx_z[a];
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        f.ca = a[9:0];
        f.cb = b[9:0];
        f.cc = c[9:0];
        f.done = last;
        f.degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
        f.nx = '0;
        f.ny = '0;
        f.nz = '0;
        if (!f.degen) begin
            top = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = cr[i] < 0 ? -cr[i] : cr[i];
                if (m[i] > top) top = m[i];
            end
            while (top >= (64'd1 << 30)) begin
                top = top >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            r = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            if (r == 0) r = 1;
            for (int i = 0; i < 3; i++) begin
                k = (m[i] << 14) / r;
                if (k > 16384) k = 16384;
                if (cr[i] < 0) k = -k;
                if (i == 0) f.nx = k[15:0];
                else if (i == 1) f.ny = k[15:0];
                else f.nz = k[15:0];
            end
        end
        return f;
    endfunction

    // Offer one item after an idle gap; update the model on acceptance
    task automatic send_item(input logic op, input int slot, input logic [23:0] px,
                             input logic [23:0] py, input logic [23:0] pz,
                             input int a, input int b, input int c, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {c[9:0], b[9:0], a[9:0], pz, py, px, slot[9:0]};
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_VERTEX) begin
            vtx_x[slot] = longint'($signed(px));
            vtx_y[slot] = longint'($signed(py));
            vtx_z[slot] = longint'($signed(pz));
            if (!slot_filled[slot]) begin
                slot_filled[slot] = 1'b1;
                filled_slots.push_back(slot);
            end
        end else begin
            pending_faces.push_back(face_normal(a, b, c, last));
        end
    endtask

    task automatic put_vertex(input int slot, input logic [23:0] px,
                              input logic [23:0] py, input logic [23:0] pz);
        send_item(OP_VERTEX, slot, px, py, pz, $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic put_triangle(input int a, input int b, input int c, input logic last);
        send_item(OP_TRIANGLE, $urandom_range(0, 1023), 24'($urandom), 24'($urandom),
                  24'($urandom), a, b, c, last);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($signed($urandom_range(0, 400)) - 200);
            3:       return 24'($signed($urandom_range(0, 80000)) - 40000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic int pick_filled();
        return filled_slots[$urandom_range(0, filled_slots.size() - 1)];
    endfunction

    // Drop the valid once the stimulus is done
    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Extremes of the coordinates and the slots, both operations
    task automatic test_extremes();
        put_vertex(0, 24'h000000, 24'h000000, 24'h000000);
        put_vertex(1023, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        put_vertex(512, 24'h800000, 24'h7FFFFF, 24'h800000);
        put_vertex(1, 24'h001000, 24'h000000, 24'h000000);
        put_vertex(2, 24'h000000, 24'h001000, 24'h000000);
        put_vertex(3, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        put_triangle(0, 1, 2, 1'b0);
        put_triangle(0, 2, 1, 1'b0);
        put_triangle(1023, 512, 3, 1'b0);
        put_triangle(512, 1023, 0, 1'b0);
        put_triangle(3, 1023, 512, 1'b1);
        put_vertex(341, 24'h555555, 24'hAAAAAA, 24'h000001);
        put_vertex(682, 24'hAAAAAA, 24'h555555, 24'hFFFFFF);
        put_triangle(341, 682, 1023, 1'b0);
        put_triangle(682, 341, 0, 1'b1);
    endtask

    // Zero cross product: repeated corners and collinear points
    task automatic test_degenerate();
        put_vertex(10, 24'h000100, 24'h000200, 24'h000300);
        put_vertex(11, 24'h000200, 24'h000400, 24'h000600);
        put_vertex(12, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        put_triangle(10, 10, 10, 1'b0);
        put_triangle(0, 10, 11, 1'b0);
        put_triangle(12, 12, 3, 1'b0);
        put_triangle(1023, 1023, 1023, 1'b1);
    endtask

    // Meshes: a few vertex writes, then triangles over stored slots; some noise
    task automatic test_random_mesh(input int rounds);
        int nv;
        int nt;
        for (int r = 0; r < rounds; r++) begin
            no_idle = ($urandom_range(0, 9) == 0);
            nv = $urandom_range(1, 4);
            nt = $urandom_range(1, 4);
            for (int i = 0; i < nv; i++)
                put_vertex($urandom_range(0, 1023), pick_coord(), pick_coord(), pick_coord());
            for (int i = 0; i < nt; i++) begin
                if ($urandom_range(0, 9) == 0)
                    put_triangle(pick_filled(), pick_filled(), pick_filled(),
                                 1'($urandom_range(0, 1)));
                else
                    put_triangle(filled_slots[filled_slots.size() - 1 - $urandom_range(0,
                                 nv - 1)], pick_filled(), pick_filled(), i == nt - 1);
            end
        end
        no_idle = 1'b0;
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        no_idle = 1'b1;
        for (int i = 0; i < 8; i++) begin
            put_vertex($urandom_range(0, 1023), pick_coord(), pick_coord(), pick_coord());
            put_triangle(pick_filled(), pick_filled(), pick_filled(), i == 7);
        end
        no_idle = 1'b0;
    endtask

    // Receiver: draw a stall after each taken result
    initial begin
        int stall;
        int last_seen;
        stall = 0;
        last_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (faces_seen != last_seen) begin
                last_seen = faces_seen;
                stall = no_idle ? 0 : $urandom_range(0, 14);
            end
            if (hold_off || stall > 0) begin
                m_axis_tready = 1'b0;
                if (!hold_off) stall = stall - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Compare each taken result with the oldest expected face
    always @(posedge i_clk) begin
        t_face f;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            faces_seen = faces_seen + 1;
            if (pending_faces.size() == 0) begin
                $error("unexpected result tdata=%h", m_axis_tdata);
                errors = errors + 1;
            end else begin
                f = pending_faces.pop_front();
                if (m_axis_tdata[15:0] !== f.nx) begin
                    $error("normal_x expected %0d got %0d", f.nx,
                           $signed(m_axis_tdata[15:0]));
                    errors = errors + 1;
                end
                if (m_axis_tdata[31:16] !== f.ny) begin
                    $error("normal_y expected %0d got %0d", f.ny,
                           $signed(m_axis_tdata[31:16]));
                    errors = errors + 1;
                end
                if (m_axis_tdata[47:32] !== f.nz) begin
                    $error("normal_z expected %0d got %0d", f.nz,
                           $signed(m_axis_tdata[47:32]));
                    errors = errors + 1;
                end
                if (m_axis_tdata[57:48] !== f.ca) begin
                    $error("out_corner_a expected %0d got %0d", f.ca, m_axis_tdata[57:48]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[67:58] !== f.cb) begin
                    $error("out_corner_b expected %0d got %0d", f.cb, m_axis_tdata[67:58]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[77:68] !== f.cc) begin
                    $error("out_corner_c expected %0d got %0d", f.cc, m_axis_tdata[77:68]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[79:78] !== 2'b00) begin
                    $error("tdata pad expected 0 got %0d", m_axis_tdata[79:78]);
                    errors = errors + 1;
                end
                if (m_axis_tuser !== f.degen) begin
                    $error("degenerate expected %0d got %0d", f.degen, m_axis_tuser);
                    errors = errors + 1;
                end
                if (m_axis_tlast !== f.done) begin
                    $error("mesh_done expected %0d got %0d", f.done, m_axis_tlast);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        errors = 0;
        faces_seen = 0;
        cycles = 0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_VERTEX;
        s_axis_tlast = 1'b0;
        for (int i = 0; i < tfn_pkg::MaxVertices; i++) slot_filled[i] = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_degenerate();
        test_random_mesh(150);
        test_backpressure();
        test_random_mesh(200);
        stop_sending();

        // Drain the expected faces, then let the pipeline settle
        while (pending_faces.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("triangle_face_normal_unit: match");
        end else begin
            $display("triangle_face_normal_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/tfn_pkg.sv
design/tfn_alu.sv
design/triangle_face_normal_unit.sv
design/tfn_checker.sv
bench/triangle_face_normal_unit_test.sv
